// File: rtl/ssc_pkg.sv
// shared constants and types for the sphere pair contact pipeline
package ssc_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int FIELD_W         = 48;
    localparam int RAD_W           = 15;
    localparam int ROT_W           = 16;
    localparam int GAP_W           = 24;
    localparam int QUO_W           = 15;
    localparam int UNIT_Q14        = 16384;
    localparam int PT_SHIFT        = 28;
    localparam int GAP_MAX         = 8388607;
    localparam int GAP_MIN         = -8388608;
    localparam int APB_DATA_W      = 32;
    localparam int APB_ADDR_W      = 3;

    typedef enum logic [0:0] {
        REG_THRESHOLD = 1'b0
    } reg_idx_t;

    typedef struct packed {
        logic [2:0][FIELD_W-1:0] a;
        logic [2:0][FIELD_W-1:0] b;
    } rot_pair_t;

    typedef struct packed {
        logic [RAD_W-1:0] radius_a;
        logic [RAD_W-1:0] radius_b;
        rot_pair_t        rot;
    } side_t;

    typedef struct packed {
        logic [FIELD_W-1:0] center_a;
        logic [FIELD_W-1:0] center_b;
        side_t              side;
    } in_beat_t;

    typedef struct packed {
        logic [GAP_W-1:0]          gap;
        logic                      separated;
        logic                      degenerate;
        logic [2:0][ROT_W-1:0]     normal;
    } head_t;

endpackage

// File: rtl/ssc_in_if.sv
// input channel carrying one sphere pair per beat
interface ssc_in_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::FIELD_W-1:0]   center_a;
    logic [ssc_pkg::FIELD_W-1:0]   center_b;
    logic [ssc_pkg::RAD_W-1:0]     radius_a;
    logic [ssc_pkg::RAD_W-1:0]     radius_b;
    logic [ssc_pkg::FIELD_W-1:0]   rot_a_row0;
    logic [ssc_pkg::FIELD_W-1:0]   rot_a_row1;
    logic [ssc_pkg::FIELD_W-1:0]   rot_a_row2;
    logic [ssc_pkg::FIELD_W-1:0]   rot_b_row0;
    logic [ssc_pkg::FIELD_W-1:0]   rot_b_row1;
    logic [ssc_pkg::FIELD_W-1:0]   rot_b_row2;

    modport source (
        output valid, center_a, center_b, radius_a, radius_b,
               rot_a_row0, rot_a_row1, rot_a_row2, rot_b_row0, rot_b_row1, rot_b_row2,
        input  ready
    );
    modport sink (
        input  valid, center_a, center_b, radius_a, radius_b,
               rot_a_row0, rot_a_row1, rot_a_row2, rot_b_row0, rot_b_row1, rot_b_row2,
        output ready
    );
endinterface

// File: rtl/ssc_out_if.sv
// output channel carrying one contact result per beat
interface ssc_out_if;
    logic                          valid;
    logic                          ready;
    logic [ssc_pkg::GAP_W-1:0]     gap;
    logic                          separated;
    logic                          degenerate;
    logic [ssc_pkg::FIELD_W-1:0]   contact_normal;
    logic [ssc_pkg::FIELD_W-1:0]   point_a;
    logic [ssc_pkg::FIELD_W-1:0]   point_b;

    modport source (
        output valid, gap, separated, degenerate, contact_normal, point_a, point_b,
        input  ready
    );
    modport sink (
        input  valid, gap, separated, degenerate, contact_normal, point_a, point_b,
        output ready
    );
endinterface

// File: rtl/ssc_prep.sv
// centre offset and squared length, two pipeline stages
module ssc_prep #(
    parameter int CW = ssc_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ssc_pkg::in_beat_t  in_beat,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2*CW+1:0]    dsq,
    output logic [2:0][CW:0]   d_out,
    output ssc_pkg::side_t     side_out
);
    import ssc_pkg::*;

    localparam int DSQ_W = 2 * CW + 2;
    localparam int EXT_W = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;

    logic [EXT_W-1:0]        ca_ext;
    logic [EXT_W-1:0]        cb_ext;
    logic [2:0][CW:0]        d0_next;
    logic [2:0][CW:0]        d0_reg;
    logic [2:0][CW:0]        d1_reg;
    side_t                   side0_reg;
    side_t                   side1_reg;
    logic signed [DSQ_W-1:0] sq [3];
    logic [DSQ_W-1:0]        dsq_next;
    logic [DSQ_W-1:0]        dsq_reg;
    logic                    v0_reg;
    logic                    v1_reg;
    logic                    rdy0;
    logic                    rdy1;

    assign rdy1     = !v1_reg || out_ready;
    assign rdy0     = !v0_reg || rdy1;
    assign in_ready = rdy0;

    assign ca_ext = EXT_W'(in_beat.center_a);
    assign cb_ext = EXT_W'(in_beat.center_b);

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d0_next[k] = {cb_ext[CW*k+CW-1], cb_ext[CW*k +: CW]}
                       - {ca_ext[CW*k+CW-1], ca_ext[CW*k +: CW]};
        end
    end

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            sq[k] = $signed(d0_reg[k]) * $signed(d0_reg[k]);
        end
        dsq_next = DSQ_W'(sq[0]) + DSQ_W'(sq[1]) + DSQ_W'(sq[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
        end
        else
        begin
            if (rdy0)
            begin
                v0_reg <= in_valid;
            end
            if (rdy1)
            begin
                v1_reg <= v0_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy0)
        begin
            d0_reg    <= d0_next;
            side0_reg <= in_beat.side;
        end
        if (rdy1)
        begin
            d1_reg    <= d0_reg;
            side1_reg <= side0_reg;
            dsq_reg   <= dsq_next;
        end
    end

    assign out_valid = v1_reg;
    assign dsq       = dsq_reg;
    assign d_out     = d1_reg;
    assign side_out  = side1_reg;

endmodule

// File: rtl/ssc_sqrt.sv
// pipelined integer square root, one result bit per stage
module ssc_sqrt #(
    parameter int CW = ssc_pkg::COORD_WIDTH_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2*CW+1:0]    dsq,
    input  logic [2:0][CW:0]   d_in,
    input  ssc_pkg::side_t     side_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [CW:0]        len,
    output logic [2:0][CW:0]   d_out,
    output ssc_pkg::side_t     side_out
);
    import ssc_pkg::*;

    localparam int LEN_W = CW + 1;
    localparam int DSQ_W = 2 * LEN_W;
    localparam int NIT   = LEN_W;

    logic             v_reg  [NIT];
    logic             v_in   [NIT];
    logic             rdy    [NIT+1];
    logic [DSQ_W-1:0] x_reg  [NIT];
    logic [DSQ_W-1:0] x_next [NIT];
    logic [DSQ_W-1:0] x_in   [NIT];
    logic [DSQ_W-1:0] r_reg  [NIT];
    logic [DSQ_W-1:0] r_next [NIT];
    logic [DSQ_W-1:0] r_in   [NIT];
    logic [2:0][CW:0] d_reg  [NIT];
    logic [2:0][CW:0] d_pass [NIT];
    side_t            side_reg  [NIT];
    side_t            side_pass [NIT];
    logic [DSQ_W-1:0] bitv;
    logic [DSQ_W-1:0] trial;

    always_comb
    begin
        rdy[NIT] = out_ready;
        for (int k = NIT - 1; k >= 0; k--)
        begin
            rdy[k] = !v_reg[k] || rdy[k+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        v_in[0]      = in_valid;
        x_in[0]      = dsq;
        r_in[0]      = '0;
        d_pass[0]    = d_in;
        side_pass[0] = side_in;
        for (int k = 1; k < NIT; k++)
        begin
            v_in[k]      = v_reg[k-1];
            x_in[k]      = x_reg[k-1];
            r_in[k]      = r_reg[k-1];
            d_pass[k]    = d_reg[k-1];
            side_pass[k] = side_reg[k-1];
        end
    end

    always_comb
    begin
        bitv  = '0;
        trial = '0;
        for (int k = 0; k < NIT; k++)
        begin
            bitv  = DSQ_W'(1) << (2 * (NIT - 1 - k));
            trial = r_in[k] + bitv;
            if (x_in[k] >= trial)
            begin
                x_next[k] = x_in[k] - trial;
                r_next[k] = (r_in[k] >> 1) + bitv;
            end
            else
            begin
                x_next[k] = x_in[k];
                r_next[k] = r_in[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NIT; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < NIT; k++)
            begin
                if (rdy[k])
                begin
                    v_reg[k] <= v_in[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < NIT; k++)
        begin
            if (rdy[k])
            begin
                x_reg[k]    <= x_next[k];
                r_reg[k]    <= r_next[k];
                d_reg[k]    <= d_pass[k];
                side_reg[k] <= side_pass[k];
            end
        end
    end

    assign out_valid = v_reg[NIT-1];
    assign len       = r_reg[NIT-1][LEN_W-1:0];
    assign d_out     = d_reg[NIT-1];
    assign side_out  = side_reg[NIT-1];

endmodule

// File: rtl/ssc_div.sv
// gap and threshold test, then pipelined normal division, one quotient bit per stage
module ssc_div #(
    parameter int CW = ssc_pkg::COORD_WIDTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic [ssc_pkg::GAP_W-1:0]  thr,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [CW:0]                len,
    input  logic [2:0][CW:0]           d_in,
    input  ssc_pkg::side_t             side_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output ssc_pkg::head_t             head_out,
    output ssc_pkg::side_t             side_out
);
    import ssc_pkg::*;

    localparam int LEN_W = CW + 1;
    localparam int NW    = CW + 17;
    localparam int DV_W  = LEN_W + 1;
    localparam int SUM_W = ((LEN_W + 2 > GAP_W) ? LEN_W + 2 : GAP_W) + 1;
    localparam int NST   = QUO_W + 1;

    logic                    v_reg  [NST+1];
    logic                    v_in   [NST+1];
    logic                    rdy    [NST+2];
    logic [2:0][NW-1:0]      rem_reg  [NST];
    logic [2:0][NW-1:0]      rem_next [NST];
    logic [2:0][QUO_W-1:0]   q_reg    [NST];
    logic [2:0][QUO_W-1:0]   q_next   [NST];
    logic [2:0]              sgn_reg  [NST];
    logic [2:0]              sgn_next [NST];
    logic [DV_W-1:0]         dv_reg   [NST];
    logic [DV_W-1:0]         dv_next  [NST];
    logic [GAP_W-1:0]        gap_reg  [NST];
    logic [GAP_W-1:0]        gap_next [NST];
    logic                    sep_reg  [NST];
    logic                    sep_next [NST];
    logic                    deg_reg  [NST];
    logic                    deg_next [NST];
    side_t                   side_reg  [NST];
    side_t                   side_next [NST];
    head_t                   head_reg;
    head_t                   head_next;
    side_t                   sideo_reg;
    logic signed [SUM_W-1:0] gsum;
    logic [CW:0]             mag;
    logic [NW-1:0]           cmp;

    always_comb
    begin
        rdy[NST+1] = out_ready;
        for (int s = NST; s >= 0; s--)
        begin
            rdy[s] = !v_reg[s] || rdy[s+1];
        end
    end

    assign in_ready = rdy[0];

    always_comb
    begin
        v_in[0] = in_valid;
        for (int s = 1; s <= NST; s++)
        begin
            v_in[s] = v_reg[s-1];
        end
    end

    // gap, threshold compare and dividend setup, then restoring division steps
    always_comb
    begin
        gsum = SUM_W'(len) - SUM_W'(side_in.radius_a) - SUM_W'(side_in.radius_b);
        if (gsum > SUM_W'(GAP_MAX))
        begin
            gap_next[0] = GAP_W'(GAP_MAX);
        end
        else if (gsum < SUM_W'(GAP_MIN))
        begin
            gap_next[0] = GAP_W'(GAP_MIN);
        end
        else
        begin
            gap_next[0] = gsum[GAP_W-1:0];
        end
        sep_next[0]  = $signed(gap_next[0]) > $signed(thr);
        deg_next[0]  = (len == '0);
        dv_next[0]   = {len, 1'b0};
        side_next[0] = side_in;
        mag          = '0;
        for (int k = 0; k < 3; k++)
        begin
            sgn_next[0][k] = d_in[k][CW];
            mag            = d_in[k][CW] ? -d_in[k] : d_in[k];
            rem_next[0][k] = (NW'(mag) << 15) + NW'(len);
            q_next[0][k]   = '0;
        end

        cmp = '0;
        for (int s = 1; s < NST; s++)
        begin
            sgn_next[s]  = sgn_reg[s-1];
            dv_next[s]   = dv_reg[s-1];
            gap_next[s]  = gap_reg[s-1];
            sep_next[s]  = sep_reg[s-1];
            deg_next[s]  = deg_reg[s-1];
            side_next[s] = side_reg[s-1];
            for (int k = 0; k < 3; k++)
            begin
                cmp = NW'(dv_reg[s-1]) << (QUO_W - s);
                if (rem_reg[s-1][k] >= cmp)
                begin
                    rem_next[s][k] = rem_reg[s-1][k] - cmp;
                    q_next[s][k]   = q_reg[s-1][k] | (QUO_W'(1) << (QUO_W - s));
                end
                else
                begin
                    rem_next[s][k] = rem_reg[s-1][k];
                    q_next[s][k]   = q_reg[s-1][k];
                end
            end
        end
    end

    always_comb
    begin
        head_next.gap        = gap_reg[NST-1];
        head_next.separated  = sep_reg[NST-1];
        head_next.degenerate = deg_reg[NST-1];
        for (int k = 0; k < 3; k++)
        begin
            if (deg_reg[NST-1])
            begin
                head_next.normal[k] = (k == 2) ? ROT_W'(UNIT_Q14) : '0;
            end
            else if (sgn_reg[NST-1][k])
            begin
                head_next.normal[k] = -ROT_W'(q_reg[NST-1][k]);
            end
            else
            begin
                head_next.normal[k] = ROT_W'(q_reg[NST-1][k]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s <= NST; s++)
            begin
                v_reg[s] <= 1'b0;
            end
        end
        else
        begin
            for (int s = 0; s <= NST; s++)
            begin
                if (rdy[s])
                begin
                    v_reg[s] <= v_in[s];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int s = 0; s < NST; s++)
        begin
            if (rdy[s])
            begin
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
                sgn_reg[s]  <= sgn_next[s];
                dv_reg[s]   <= dv_next[s];
                gap_reg[s]  <= gap_next[s];
                sep_reg[s]  <= sep_next[s];
                deg_reg[s]  <= deg_next[s];
                side_reg[s] <= side_next[s];
            end
        end
        if (rdy[NST])
        begin
            head_reg  <= head_next;
            sideo_reg <= side_reg[NST-1];
        end
    end

    assign out_valid = v_reg[NST];
    assign head_out  = head_reg;
    assign side_out  = sideo_reg;

endmodule

// File: rtl/ssc_xform.sv
// contact points in each sphere frame: scale, rotate, sum, round and saturate
module ssc_xform #(
    parameter int CW = ssc_pkg::COORD_WIDTH_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ssc_pkg::head_t               head_in,
    input  ssc_pkg::side_t               side_in,
    output logic                         out_valid,
    input  logic                         out_ready,
    output ssc_pkg::head_t               head_out,
    output logic [ssc_pkg::FIELD_W-1:0]  point_a,
    output logic [ssc_pkg::FIELD_W-1:0]  point_b
);
    import ssc_pkg::*;

    localparam int VW    = 32;
    localparam int PW    = 48;
    localparam int AW    = PW + 2;
    localparam int RW    = AW - PT_SHIFT;
    localparam int EXT_W = (3 * CW > FIELD_W) ? 3 * CW : FIELD_W;
    localparam logic [RW-1:0] CMAX = RW'((1 << (CW - 1)) - 1);

    logic              va_v_reg;
    logic              pb_v_reg;
    logic              ac_v_reg;
    logic              out_v_reg;
    logic              rdy_a;
    logic              rdy_b;
    logic              rdy_c;
    logic              rdy_d;
    head_t             ha_reg;
    head_t             hb_reg;
    head_t             hc_reg;
    head_t             hd_reg;
    rot_pair_t         rot_reg;
    logic signed [VW-1:0] v_next [2][3];
    logic signed [VW-1:0] v_reg  [2][3];
    logic signed [PW-1:0] p_next [2][3][3];
    logic signed [PW-1:0] p_reg  [2][3][3];
    logic signed [AW-1:0] acc_next [2][3];
    logic signed [AW-1:0] acc_reg  [2][3];
    logic [AW-1:0]        amag;
    logic [AW-1:0]        rsum;
    logic [RW-1:0]        rmag;
    logic [CW-1:0]        lane_val;
    logic [EXT_W-1:0]     pk [2];
    logic [FIELD_W-1:0]   pt_next [2];
    logic [FIELD_W-1:0]   pa_reg;
    logic [FIELD_W-1:0]   pb_reg;
    logic [ROT_W-1:0]     rlane;

    assign rdy_d    = !out_v_reg || out_ready;
    assign rdy_c    = !ac_v_reg || rdy_d;
    assign rdy_b    = !pb_v_reg || rdy_c;
    assign rdy_a    = !va_v_reg || rdy_b;
    assign in_ready = rdy_a;

    // normal scaled by the radius, negated for sphere b
    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            v_next[0][j] = $signed(head_in.normal[j]) * $signed({1'b0, side_in.radius_a});
            v_next[1][j] = -($signed(head_in.normal[j]) * $signed({1'b0, side_in.radius_b}));
        end
    end

    always_comb
    begin
        rlane = '0;
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rlane = (s == 0) ? rot_reg.a[j][ROT_W*i +: ROT_W]
                                     : rot_reg.b[j][ROT_W*i +: ROT_W];
                    p_next[s][i][j] = $signed(rlane) * v_reg[s][j];
                end
            end
        end
    end

    always_comb
    begin
        for (int s = 0; s < 2; s++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                acc_next[s][i] = p_reg[s][i][0] + p_reg[s][i][1] + p_reg[s][i][2];
            end
        end
    end

    // round half away from zero, saturate to the lane and pack
    always_comb
    begin
        amag     = '0;
        rsum     = '0;
        rmag     = '0;
        lane_val = '0;
        for (int s = 0; s < 2; s++)
        begin
            pk[s] = '0;
            for (int i = 0; i < 3; i++)
            begin
                amag = acc_reg[s][i][AW-1] ? AW'(-acc_reg[s][i]) : AW'(acc_reg[s][i]);
                rsum = amag + (AW'(1) << (PT_SHIFT - 1));
                rmag = rsum[AW-1:PT_SHIFT];
                if (acc_reg[s][i][AW-1])
                begin
                    if (rmag > CMAX + RW'(1))
                    begin
                        lane_val = {1'b1, {(CW-1){1'b0}}};
                    end
                    else
                    begin
                        lane_val = -rmag[CW-1:0];
                    end
                end
                else
                begin
                    if (rmag > CMAX)
                    begin
                        lane_val = {1'b0, {(CW-1){1'b1}}};
                    end
                    else
                    begin
                        lane_val = rmag[CW-1:0];
                    end
                end
                pk[s][CW*i +: CW] = lane_val;
            end
            pt_next[s] = hc_reg.separated ? '0 : pk[s][FIELD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_v_reg  <= 1'b0;
            pb_v_reg  <= 1'b0;
            ac_v_reg  <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (rdy_a)
            begin
                va_v_reg <= in_valid;
            end
            if (rdy_b)
            begin
                pb_v_reg <= va_v_reg;
            end
            if (rdy_c)
            begin
                ac_v_reg <= pb_v_reg;
            end
            if (rdy_d)
            begin
                out_v_reg <= ac_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy_a)
        begin
            v_reg   <= v_next;
            ha_reg  <= head_in;
            rot_reg <= side_in.rot;
        end
        if (rdy_b)
        begin
            p_reg  <= p_next;
            hb_reg <= ha_reg;
        end
        if (rdy_c)
        begin
            acc_reg <= acc_next;
            hc_reg  <= hb_reg;
        end
        if (rdy_d)
        begin
            pa_reg               <= pt_next[0];
            pb_reg               <= pt_next[1];
            hd_reg.gap           <= hc_reg.gap;
            hd_reg.separated     <= hc_reg.separated;
            hd_reg.degenerate    <= hc_reg.degenerate && !hc_reg.separated;
            hd_reg.normal        <= hc_reg.separated ? '0 : hc_reg.normal;
        end
    end

    assign out_valid = out_v_reg;
    assign head_out  = hd_reg;
    assign point_a   = pa_reg;
    assign point_b   = pb_reg;

endmodule

// File: rtl/sphere_sphere_contact.sv
// top level of the sphere pair contact pipeline
//
// req carries one sphere pair per beat: two centres, two radii, two rotations.
// rsp carries one result per beat: gap, separated, degenerate, normal and the
// two contact points, in the order the pairs were accepted.
// contact_threshold is written over the apb port at address 0; the user must write
// it only while the pipeline holds no pairs, and the block does not enforce that.
// A pair whose gap is above the threshold comes out separated with only the gap filled in.
// the pipeline is two offset stages, one square root stage per length bit, a
// gap stage, fifteen divider stages, a normal stage and four point stages.
// throughput is one pair per cycle while rsp is not stalled; every stage has its own
// valid bit and takes a new beat whenever it is empty or its successor moves.
// when rsp is stalled, the full stages hold and the empty ones keep filling,
// so req stays ready until the pipeline is full.
// reset empties the pipeline and clears the threshold to zero.
module sphere_sphere_contact #(
    parameter int COORD_WIDTH = ssc_pkg::COORD_WIDTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    ssc_in_if.sink                            req,
    ssc_out_if.source                         rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ssc_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ssc_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ssc_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);
    import ssc_pkg::*;

    localparam int CW = COORD_WIDTH;

    logic [GAP_W-1:0]  thr_reg;
    in_beat_t          in_beat;
    reg_idx_t          reg_idx;

    logic              pr_valid;
    logic              pr_ready;
    logic [2*CW+1:0]   pr_dsq;
    logic [2:0][CW:0]  pr_d;
    side_t             pr_side;

    logic              sq_valid;
    logic              sq_ready;
    logic [CW:0]       sq_len;
    logic [2:0][CW:0]  sq_d;
    side_t             sq_side;

    logic              dv_valid;
    logic              dv_ready;
    head_t             dv_head;
    side_t             dv_side;

    head_t             xf_head;

    assign reg_idx = reg_idx_t'(paddr[2]);
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            case (reg_idx)
                REG_THRESHOLD: thr_reg <= pwdata[GAP_W-1:0];
                default:       thr_reg <= thr_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_THRESHOLD: prdata = {{(APB_DATA_W-GAP_W){thr_reg[GAP_W-1]}}, thr_reg};
            default:       prdata = '0;
        endcase
    end

    assign in_beat.center_a        = req.center_a;
    assign in_beat.center_b        = req.center_b;
    assign in_beat.side.radius_a   = req.radius_a;
    assign in_beat.side.radius_b   = req.radius_b;
    assign in_beat.side.rot.a[0]   = req.rot_a_row0;
    assign in_beat.side.rot.a[1]   = req.rot_a_row1;
    assign in_beat.side.rot.a[2]   = req.rot_a_row2;
    assign in_beat.side.rot.b[0]   = req.rot_b_row0;
    assign in_beat.side.rot.b[1]   = req.rot_b_row1;
    assign in_beat.side.rot.b[2]   = req.rot_b_row2;

    ssc_prep #(.CW(CW)) u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_beat   (in_beat),
        .out_valid (pr_valid),
        .out_ready (pr_ready),
        .dsq       (pr_dsq),
        .d_out     (pr_d),
        .side_out  (pr_side)
    );

    ssc_sqrt #(.CW(CW)) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (pr_valid),
        .in_ready  (pr_ready),
        .dsq       (pr_dsq),
        .d_in      (pr_d),
        .side_in   (pr_side),
        .out_valid (sq_valid),
        .out_ready (sq_ready),
        .len       (sq_len),
        .d_out     (sq_d),
        .side_out  (sq_side)
    );

    ssc_div #(.CW(CW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .thr       (thr_reg),
        .in_valid  (sq_valid),
        .in_ready  (sq_ready),
        .len       (sq_len),
        .d_in      (sq_d),
        .side_in   (sq_side),
        .out_valid (dv_valid),
        .out_ready (dv_ready),
        .head_out  (dv_head),
        .side_out  (dv_side)
    );

    ssc_xform #(.CW(CW)) u_xform (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dv_valid),
        .in_ready  (dv_ready),
        .head_in   (dv_head),
        .side_in   (dv_side),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .head_out  (xf_head),
        .point_a   (rsp.point_a),
        .point_b   (rsp.point_b)
    );

    assign rsp.gap            = xf_head.gap;
    assign rsp.separated      = xf_head.separated;
    assign rsp.degenerate     = xf_head.degenerate;
    assign rsp.contact_normal = xf_head.normal;

endmodule

// File: rtl/ssc_check.sv
// port-level checks on the contact pipeline, bound to the top level
module ssc_check (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              rsp_valid,
    input logic                              rsp_ready,
    input logic [ssc_pkg::GAP_W-1:0]         gap,
    input logic                              separated,
    input logic                              degenerate,
    input logic [ssc_pkg::FIELD_W-1:0]       contact_normal,
    input logic [ssc_pkg::FIELD_W-1:0]       point_a,
    input logic [ssc_pkg::FIELD_W-1:0]       point_b
);
    import ssc_pkg::*;

    a_reset_empty: assert property (@(posedge clk) !rst_n |=> !rsp_valid)
        else $error("result valid during reset");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(gap) && $stable(point_a))
        else $error("stalled result changed");

    a_sep_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && separated |-> !degenerate && contact_normal == '0
                                   && point_a == '0 && point_b == '0)
        else $error("separated result carries contact data");

    a_deg_normal: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && degenerate |-> !separated
            && contact_normal == {ROT_W'(UNIT_Q14), {(2*ROT_W){1'b0}}})
        else $error("degenerate result without default normal");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !separated |->
            $signed(contact_normal[15:0]) <= 16'sd16384
            && $signed(contact_normal[15:0]) >= -16'sd16384)
        else $error("normal lane outside unit range");

endmodule

bind sphere_sphere_contact ssc_check u_ssc_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .gap            (rsp.gap),
    .separated      (rsp.separated),
    .degenerate     (rsp.degenerate),
    .contact_normal (rsp.contact_normal),
    .point_a        (rsp.point_a),
    .point_b        (rsp.point_b)
);
